@@ rtl/radix_base_converter_core_assert.svh @@
`ifndef RADIX_BASE_CONVERTER_CORE_ASSERT_SVH
`define RADIX_BASE_CONVERTER_CORE_ASSERT_SVH

// Same-cycle check: consequent must hold whenever antecedent holds.
`define RBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle check: consequent must hold in the cycle after antecedent.
`define RBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rbc_pkg.sv @@
`timescale 1ns / 1ps

package rbc_pkg;

  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 8;
  localparam int ST_W    = 2;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [ST_W-1:0]    status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BADDIGIT = 2'd1;
  localparam status_t ST_OVERFLOW = 2'd2;

  localparam logic REG_SOURCE_BASE = 1'b0;
  localparam logic REG_TARGET_BASE = 1'b1;

  localparam digit_t BASE_MIN   = 6'd2;
  localparam digit_t BASE_MAX   = 6'd36;
  localparam digit_t BASE_RESET = 6'd10;
  localparam digit_t DIGIT_BAD  = 6'd63;

  localparam char_t CHAR_MINUS = 8'h2D;
  localparam char_t CHAR_ZERO  = 8'h30;
  localparam char_t CHAR_NINE  = 8'h39;
  localparam char_t CHAR_A     = 8'h41;
  localparam char_t CHAR_Z     = 8'h5A;
  localparam char_t CHAR_NUL   = 8'h00;

  function automatic digit_t clamp_base(input digit_t b);
    if (b < BASE_MIN) return BASE_MIN;
    if (b > BASE_MAX) return BASE_MAX;
    return b;
  endfunction

  function automatic digit_t char_value(input char_t c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return DIGIT_W'(c - CHAR_ZERO);
    if (c >= CHAR_A && c <= CHAR_Z) return DIGIT_W'(c - CHAR_A + 8'd10);
    return DIGIT_BAD;
  endfunction

  function automatic char_t digit_char(input digit_t v);
    if (v < 6'd10) return CHAR_ZERO + CHAR_W'(v);
    return CHAR_A + CHAR_W'(v - 6'd10);
  endfunction

endpackage

@@ rtl/rbc_ram.sv @@
`timescale 1ns / 1ps

module rbc_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/rbc_div.sv @@
`timescale 1ns / 1ps

module rbc_div
  import rbc_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  digit_t                divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output digit_t                remainder
);

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic                  busy;
  logic [CNT_W-1:0]      count;
  logic [VALUE_BITS-1:0] quo;
  digit_t                rem;
  digit_t                dvs;
  logic [DIGIT_W:0]      cand;
  digit_t                diff;
  logic                  ge;

  assign cand = {rem, quo[VALUE_BITS-1]};
  assign diff = cand[DIGIT_W-1:0] - dvs;
  assign ge   = cand >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && (count == '0);
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(VALUE_BITS - 1);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[VALUE_BITS-2:0], ge};
      rem <= ge ? diff : cand[DIGIT_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

@@ rtl/radix_base_converter_core.sv @@
`timescale 1ns / 1ps

// Signed numeral converter between radices 2..36. Characters of the source
// numeral ('-' first if negative, digits '0'-'9', 'A'-'Z') arrive one per
// request on the slave side, tlast on the final one. Each character is
// accepted, then gets one multiply-add and range compare. After the final
// character the magnitude is taken apart by a shared restoring divider that
// yields one quotient bit per cycle; each digit is written to a small digit
// buffer, and the digits are then sent most significant first, with a '-'
// ahead when the value is negative. An invalid digit or a value outside the
// VALUE_BITS-bit signed range gives one request with status set, char 0 and
// tlast. The block takes no character while a numeral is being converted or
// sent. The radix registers are written through the cfg channel (index 0
// source, 1 target); the user must write them only while idle, as the block
// itself does not enforce this. Out-of-range values act as 2 or 36.
module radix_base_converter_core
  import rbc_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [5:0]   cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] char_in
  input  logic         s_tlast,   // char_last
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata,   // [7:0] char_out
  output logic         m_tlast,   // out_last
  output logic [1:0]   m_tuser    // [1:0] status
);

  localparam int PW   = VALUE_BITS + DIGIT_W;
  localparam int CW   = $clog2(VALUE_BITS + 1);
  localparam int AW   = $clog2(VALUE_BITS);
  localparam logic [PW-1:0] POS_LIMIT = (PW'(1) << (VALUE_BITS - 1)) - PW'(1);
  localparam logic [PW-1:0] NEG_LIMIT = PW'(1) << (VALUE_BITS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ACC   = 3'd1;
  localparam logic [2:0] S_FIN   = 3'd2;
  localparam logic [2:0] S_DIVW  = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_LOAD  = 3'd5;
  localparam logic [2:0] S_OWAIT = 3'd6;

  logic [2:0]            state;
  digit_t                source_base;
  digit_t                target_base;
  char_t                 ch;
  logic                  ch_last;
  logic [VALUE_BITS-1:0] magnitude;
  logic                  negative_flag;
  status_t               error_code;
  logic                  at_first_char;
  logic [CW-1:0]         digit_count;

  char_t                 out_char;
  logic                  out_last;
  status_t               out_status;
  logic                  out_valid;

  digit_t                sb;
  digit_t                tb;
  digit_t                dval;
  logic [PW-1:0]         prod;
  logic [PW-1:0]         limit;
  logic [CW-1:0]         cnt_inc;
  logic [CW-1:0]         cnt_dec;
  logic                  more_digits;

  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quo;
  digit_t                div_rem;
  digit_t                ram_rdata;

  assign sb          = clamp_base(source_base);
  assign tb          = clamp_base(target_base);
  assign dval        = char_value(ch);
  assign prod        = {{DIGIT_W{1'b0}}, magnitude} * PW'(sb) + PW'(dval);
  assign limit       = negative_flag ? NEG_LIMIT : POS_LIMIT;
  assign cnt_inc     = digit_count + 1'b1;
  assign cnt_dec     = digit_count - 1'b1;
  assign more_digits = (div_quo != '0) && (cnt_inc < CW'(VALUE_BITS));
  assign div_start   = ((state == S_FIN) && (error_code == ST_OK)) ||
                       ((state == S_DIVW) && div_done && more_digits);

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_char;
  assign m_tlast   = out_last;
  assign m_tuser   = out_status;

  rbc_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ((state == S_FIN) ? magnitude : div_quo),
    .divisor  (tb),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  rbc_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(VALUE_BITS)
  ) u_digits (
    .clk  (clk),
    .we   ((state == S_DIVW) && div_done),
    .waddr(digit_count[AW-1:0]),
    .wdata(div_rem),
    .raddr(cnt_dec[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      source_base <= BASE_RESET;
      target_base <= BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_SOURCE_BASE) begin
        source_base <= cfg_data;
      end else begin
        target_base <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      magnitude     <= '0;
      negative_flag <= 1'b0;
      error_code    <= ST_OK;
      at_first_char <= 1'b1;
      digit_count   <= '0;
      out_valid     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (error_code == ST_OK) begin
            if (at_first_char && ch == CHAR_MINUS) begin
              negative_flag <= 1'b1;
            end else if (dval >= sb) begin
              error_code <= ST_BADDIGIT;
            end else if (prod > limit) begin
              error_code <= ST_OVERFLOW;
            end else begin
              magnitude <= prod[VALUE_BITS-1:0];
            end
          end
          at_first_char <= 1'b0;
          state         <= ch_last ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          digit_count <= '0;
          if (error_code != ST_OK) begin
            out_valid <= 1'b1;
            state     <= S_OWAIT;
          end else begin
            state <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            digit_count <= cnt_inc;
            if (!more_digits) begin
              if (negative_flag && magnitude != '0) begin
                out_valid <= 1'b1;
                state     <= S_OWAIT;
              end else begin
                state <= S_RD;
              end
            end
          end
        end
        S_RD: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          digit_count <= cnt_dec;
          out_valid   <= 1'b1;
          state       <= S_OWAIT;
        end
        S_OWAIT: begin
          if (m_tready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              magnitude     <= '0;
              negative_flag <= 1'b0;
              error_code    <= ST_OK;
              at_first_char <= 1'b1;
              digit_count   <= '0;
              state         <= S_IDLE;
            end else begin
              state <= S_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ch      <= s_tdata;
      ch_last <= s_tlast;
    end
    if (state == S_FIN) begin
      out_char   <= CHAR_NUL;
      out_last   <= 1'b1;
      out_status <= error_code;
    end else if (state == S_DIVW) begin
      out_char   <= CHAR_MINUS;
      out_last   <= 1'b0;
      out_status <= ST_OK;
    end else if (state == S_LOAD) begin
      out_char   <= digit_char(ram_rdata);
      out_last   <= (digit_count == CW'(1));
      out_status <= ST_OK;
    end
  end

  `include "radix_base_converter_core_assert.svh"

  `RBC_ASSERT_NOW(a_no_overlap, s_tready, !m_tvalid, "input taken while result pending")
  `RBC_ASSERT_NOW(a_err_form, m_tvalid && m_tuser != ST_OK, m_tdata == CHAR_NUL && m_tlast,
    "error result malformed")
  `RBC_ASSERT_NOW(a_cnt_range, 1'b1, digit_count <= CW'(VALUE_BITS), "digit count overrun")
  `RBC_ASSERT_NOW(a_div_owner, div_done, state == S_DIVW, "divider result outside conversion")
  `RBC_ASSERT_NEXT(a_last_idle, m_tvalid && m_tready && m_tlast, s_tready,
    "not idle after final result")

endmodule
